/* rtl/core/msp_pkg.sv */
package msp_pkg;

    localparam logic [7:0] CRC_POLY   = 8'hD5;
    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_M      = 8'h4D;
    localparam logic [7:0] CHR_X      = 8'h58;
    localparam logic [7:0] CHR_LT     = 8'h3C;
    localparam logic [7:0] CHR_GT     = 8'h3E;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_HDR2     = 4'd1,
        PH_DIR      = 4'd2,
        PH_FLAGS    = 4'd3,
        PH_V2CMDLO  = 4'd4,
        PH_V2CMDHI  = 4'd5,
        PH_V2SIZELO = 4'd6,
        PH_V2SIZEHI = 4'd7,
        PH_V1SIZE   = 4'd8,
        PH_V1CMD    = 4'd9,
        PH_PAYLOAD  = 4'd10,
        PH_CHECK    = 4'd11
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic        frame_good;
        logic        version;
        logic        dir_to_host;
        logic [15:0] command_id;
        logic [15:0] payload_length;
        logic [7:0]  flag_bits;
    } t_result;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = {v[6:0], 1'b0} ^ (v[7] ? CRC_POLY : 8'h00);
        end
        return v;
    endfunction

endpackage

/* rtl/core/msp_out_slice.sv */
module msp_out_slice
    import msp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    w_push;

    assign o_ready = !r_skid_valid;
    assign w_push  = i_valid && o_ready;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || i_ready) begin
            // advance: skid beat first, else the new beat
            n_main       = r_skid_valid ? r_skid : i_data;
            n_main_valid = r_skid_valid || w_push;
            n_skid_valid = 1'b0;
        end else if (w_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    a_skid_implies_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid holds a beat while output register is empty");

    a_stall_keeps_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_valid && !i_ready |=> r_main_valid && $stable(r_main))
        else $error("stalled output beat changed");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_valid && !i_ready && w_push |=> r_skid_valid)
        else $error("beat lost during stall");

endmodule

/* rtl/core/msp_frame_parser.sv */
// MSP v1/v2 frame parser.
// Input channel: one received byte per beat on i_rx_byte, handshake
// i_in_valid / o_in_ready. Output channel: zero or one result per input
// byte, handshake o_out_valid / i_out_ready, fields on o_kind, o_data_byte,
// o_byte_index, o_frame_good, o_version, o_dir_to_host, o_command_id,
// o_payload_length and o_flag_bits.
// Each payload byte is forwarded as a kind 0 result; the check byte yields a
// kind 1 result carrying the checksum (v1) or CRC-8 DVB-S2 (v2) verdict.
// Header, flags, command and size bytes produce no result.
// Each result is registered in the output slice. Throughput: one byte per
// cycle while o_in_ready is high; the header state machine and a one-byte
// CRC step sit between the input port and the output register.
// A two-entry output slice decouples the sides: while the receiver stalls,
// bytes that yield no result still pass and one more result is held, then
// o_in_ready drops until the receiver takes a beat.
// Reset (synchronous, active low) returns the parser to hunting for '$' and
// empties the output slice.
module msp_frame_parser
    import msp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_byte_index,
    output logic        o_frame_good,
    output logic        o_version,
    output logic        o_dir_to_host,
    output logic [15:0] o_command_id,
    output logic [15:0] o_payload_length,
    output logic [7:0]  o_flag_bits
);

    t_phase      r_phase, n_phase;
    logic        r_is_v2, n_is_v2;
    logic        r_dir_flag, n_dir_flag;
    logic [7:0]  r_flags_seen, n_flags_seen;
    logic [15:0] r_size_seen, n_size_seen;
    logic [15:0] r_command_seen, n_command_seen;
    logic [15:0] r_payload_count, n_payload_count;
    logic [7:0]  r_xor_sum, n_xor_sum;
    logic [7:0]  r_crc_sum, n_crc_sum;

    logic        w_accept;
    logic        w_res_valid;
    logic [7:0]  w_crc_next;
    logic [15:0] w_count_inc;
    t_result     w_res;
    t_result     w_out;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_crc_next  = crc8_step(r_crc_sum, i_rx_byte);
    assign w_count_inc = r_payload_count + 16'd1;

    always_comb begin
        n_phase         = r_phase;
        n_is_v2         = r_is_v2;
        n_dir_flag      = r_dir_flag;
        n_flags_seen    = r_flags_seen;
        n_size_seen     = r_size_seen;
        n_command_seen  = r_command_seen;
        n_payload_count = r_payload_count;
        n_xor_sum       = r_xor_sum;
        n_crc_sum       = r_crc_sum;
        case (r_phase)
            PH_HDR2: begin
                if (i_rx_byte == CHR_M) begin
                    n_is_v2 = 1'b0;
                    n_phase = PH_DIR;
                end else if (i_rx_byte == CHR_X) begin
                    n_is_v2 = 1'b1;
                    n_phase = PH_DIR;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_DIR: begin
                if (i_rx_byte == CHR_LT || i_rx_byte == CHR_GT) begin
                    n_dir_flag      = (i_rx_byte == CHR_GT);
                    n_flags_seen    = '0;
                    n_size_seen     = '0;
                    n_command_seen  = '0;
                    n_payload_count = '0;
                    n_xor_sum       = '0;
                    n_crc_sum       = '0;
                    n_phase         = r_is_v2 ? PH_FLAGS : PH_V1SIZE;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_FLAGS: begin
                n_flags_seen = i_rx_byte;
                n_crc_sum    = w_crc_next;
                n_phase      = PH_V2CMDLO;
            end
            PH_V2CMDLO: begin
                n_command_seen = {8'h00, i_rx_byte};
                n_crc_sum      = w_crc_next;
                n_phase        = PH_V2CMDHI;
            end
            PH_V2CMDHI: begin
                n_command_seen = {i_rx_byte, r_command_seen[7:0]};
                n_crc_sum      = w_crc_next;
                n_phase        = PH_V2SIZELO;
            end
            PH_V2SIZELO: begin
                n_size_seen = {8'h00, i_rx_byte};
                n_crc_sum   = w_crc_next;
                n_phase     = PH_V2SIZEHI;
            end
            PH_V2SIZEHI: begin
                n_size_seen = {i_rx_byte, r_size_seen[7:0]};
                n_crc_sum   = w_crc_next;
                n_phase     = (n_size_seen != 16'd0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_V1SIZE: begin
                n_size_seen = {8'h00, i_rx_byte};
                n_xor_sum   = r_xor_sum ^ i_rx_byte;
                n_phase     = PH_V1CMD;
            end
            PH_V1CMD: begin
                n_command_seen = {8'h00, i_rx_byte};
                n_xor_sum      = r_xor_sum ^ i_rx_byte;
                n_phase        = (r_size_seen != 16'd0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
                if (r_is_v2) begin
                    n_crc_sum = w_crc_next;
                end else begin
                    n_xor_sum = r_xor_sum ^ i_rx_byte;
                end
                n_payload_count = w_count_inc;
                if (w_count_inc >= r_size_seen) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = (i_rx_byte == CHR_DOLLAR) ? PH_HDR2 : PH_IDLE;
            end
        endcase
    end

    always_comb begin
        w_res_valid          = 1'b0;
        w_res.kind           = KIND_PAYLOAD;
        w_res.data_byte      = 8'h00;
        w_res.byte_index     = 16'd0;
        w_res.frame_good     = 1'b0;
        w_res.version        = r_is_v2;
        w_res.dir_to_host    = r_dir_flag;
        w_res.command_id     = r_command_seen;
        w_res.payload_length = r_size_seen;
        w_res.flag_bits      = r_flags_seen;
        case (r_phase)
            PH_PAYLOAD: begin
                w_res_valid      = w_accept;
                w_res.data_byte  = i_rx_byte;
                w_res.byte_index = r_payload_count;
            end
            PH_CHECK: begin
                w_res_valid      = w_accept;
                w_res.kind       = KIND_FRAME_END;
                w_res.frame_good = (i_rx_byte == (r_is_v2 ? r_crc_sum : r_xor_sum));
            end
            default: begin
                w_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_is_v2         <= 1'b0;
            r_dir_flag      <= 1'b0;
            r_flags_seen    <= '0;
            r_size_seen     <= '0;
            r_command_seen  <= '0;
            r_payload_count <= '0;
            r_xor_sum       <= '0;
            r_crc_sum       <= '0;
        end else if (w_accept) begin
            r_phase         <= n_phase;
            r_is_v2         <= n_is_v2;
            r_dir_flag      <= n_dir_flag;
            r_flags_seen    <= n_flags_seen;
            r_size_seen     <= n_size_seen;
            r_command_seen  <= n_command_seen;
            r_payload_count <= n_payload_count;
            r_xor_sum       <= n_xor_sum;
            r_crc_sum       <= n_crc_sum;
        end
    end

    msp_out_slice u_out_slice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (o_in_ready),
        .i_data  (w_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_out)
    );

    assign o_kind           = w_out.kind;
    assign o_data_byte      = w_out.data_byte;
    assign o_byte_index     = w_out.byte_index;
    assign o_frame_good     = w_out.frame_good;
    assign o_version        = w_out.version;
    assign o_dir_to_host    = w_out.dir_to_host;
    assign o_command_id     = w_out.command_id;
    assign o_payload_length = w_out.payload_length;
    assign o_flag_bits      = w_out.flag_bits;

    a_payload_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_payload_count < r_size_seen)
        else $error("payload count reached declared size inside payload");

    a_payload_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_phase == PH_PAYLOAD |=> r_phase == PH_PAYLOAD || r_phase == PH_CHECK)
        else $error("payload left without check byte");

    a_check_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_phase == PH_CHECK |=> r_phase == PH_IDLE && o_out_valid)
        else $error("frame end not delivered or parser not back to hunting");

endmodule
